FILE: sv/kwq_pkg.sv
package kwq_pkg;

  localparam int MaxKeysDef    = 16;
  localparam int QueueDepthDef = 16;
  localparam int IdW           = 16;
  localparam int CatW          = 2;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_ENQ  = 2'd1,
    CMD_DEQ  = 2'd2,
    CMD_LIST = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NOKEY = 3'd1,
    ST_TFULL = 3'd2,
    ST_QFULL = 3'd3,
    ST_EMPTY = 3'd4,
    ST_DUP   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADDK,
    S_NOKEY,
    S_MRD,
    S_MLD,
    S_ENQ,
    S_DQ1,
    S_DQ2,
    S_DQ3,
    S_LIST,
    S_FIN
  } state_e;

endpackage

FILE: sv/kwq_in_if.sv
interface kwq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] key_code;
  logic [15:0] member_id;
  logic [1:0]  category;

  modport source (output valid, cmd, key_code, member_id, category, input ready);
  modport sink (input valid, cmd, key_code, member_id, category, output ready);
endinterface

FILE: sv/kwq_out_if.sv
interface kwq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] entry_id;
  logic        entry_valid;
  logic [15:0] next_id;
  logic        next_valid;
  logic        last;

  modport source (output valid, status, entry_id, entry_valid, next_id, next_valid, last,
                  input ready);
  modport sink (input valid, status, entry_id, entry_valid, next_id, next_valid, last,
                output ready);
endinterface

FILE: sv/kwq_ram.sv
module kwq_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/keyed_wait_queue_table.sv
// The key memory is scanned one slot a cycle over all MAX_KEYS slots, and each result is
// registered. Add key and unknown key answer after the scan; enqueue and dequeue first read the
// queue metadata, and a non-empty dequeue then reads the head and next entries. A list walks its
// queue one entry a cycle while the output is not stalled and gives its final result after the walk.
// One item at a time: the next transfer is taken only in idle, which the sequencer enters as the
// final result is registered. Reset clears slot valid bits, the sequencer and output valid only.
module keyed_wait_queue_table #(
  parameter int MAX_KEYS    = kwq_pkg::MaxKeysDef,
  parameter int QUEUE_DEPTH = kwq_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwq_in_if.sink    in_i,
  kwq_out_if.source out_o
);
  import kwq_pkg::*;

  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ED = MAX_KEYS * QUEUE_DEPTH;
  localparam int AW = (ED > 1) ? $clog2(ED) : 1;
  localparam int MW = QW + CW;
  localparam int EW = CatW + IdW;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q;
  logic [IdW-1:0]    code_q, mid_q;
  logic [CatW-1:0]   cat_q;
  logic [KW:0]       idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [KW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d, free_fnd_q, free_fnd_d;
  logic [KW-1:0]     slot_q, slot_d, free_q, free_d;
  logic [MAX_KEYS-1:0] used_q, used_d;
  logic [QW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     lidx_q, lidx_d;
  logic              rdv_q, rdv_d;
  logic [IdW-1:0]    pend_q, pend_d, rem_q, rem_d;
  logic              pend_vld_q, pend_vld_d;

  logic              out_vld_q;
  logic [2:0]        o_st_q;
  logic [IdW-1:0]    o_eid_q, o_nid_q;
  logic              o_ev_q, o_nv_q, o_last_q;

  logic              can_emit, emit;
  status_e           e_st;
  logic [IdW-1:0]    e_eid, e_nid;
  logic              e_ev, e_nv, e_last;

  logic              key_we, meta_we, ent_we;
  logic [KW-1:0]     key_raddr, meta_waddr;
  logic [IdW-1:0]    key_rdata;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic [AW-1:0]     ent_raddr, ent_waddr;
  logic [EW-1:0]     ent_wdata, ent_rdata;
  logic [QW-1:0]     head_nx;
  logic [CW-1:0]     lidx_m1;
  logic              step;

  function automatic logic [AW-1:0] ent_addr(input logic [KW-1:0] s,
                                              input logic [QW-1:0] h,
                                              input logic [QW-1:0] off);
    logic [QW:0] sum;
    sum = {1'b0, h} + {1'b0, off};
    if (sum >= (QW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (QW+1)'(QUEUE_DEPTH);
    end
    return AW'(s) * AW'(QUEUE_DEPTH) + AW'(sum);
  endfunction

  kwq_ram #(.Width(IdW), .Depth(MAX_KEYS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_q),
    .wdata_i (code_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  kwq_ram #(.Width(MW), .Depth(MAX_KEYS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (slot_q),
    .rdata_o (meta_rdata)
  );

  kwq_ram #(.Width(EW), .Depth(ED)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign can_emit  = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign key_raddr = idx_q[KW-1:0];
  assign head_nx   = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign lidx_m1   = lidx_q - 1'b1;
  assign step      = can_emit;
  assign ent_waddr = ent_addr(slot_q, head_q, cnt_q[QW-1:0]);
  assign ent_wdata = {cat_q, mid_q};

  always_comb begin
    case (state_q)
      S_DQ1:          ent_raddr = ent_addr(slot_q, head_q, '0);
      S_DQ2, S_DQ3:   ent_raddr = ent_addr(slot_q, head_q, QW'(1));
      S_LIST:         ent_raddr = ent_addr(slot_q, head_q,
                                           step ? lidx_q[QW-1:0] : lidx_m1[QW-1:0]);
      default:        ent_raddr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    found_d    = found_q;
    slot_d     = slot_q;
    free_fnd_d = free_fnd_q;
    free_d     = free_q;
    used_d     = used_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    lidx_d     = lidx_q;
    rdv_d      = rdv_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    rem_d      = rem_q;
    key_we     = 1'b0;
    meta_we    = 1'b0;
    ent_we     = 1'b0;
    meta_waddr = slot_q;
    meta_wdata = '0;
    emit       = 1'b0;
    e_st       = ST_OK;
    e_eid      = '0;
    e_ev       = 1'b0;
    e_nid      = '0;
    e_nv       = 1'b0;
    e_last     = 1'b1;
    case (state_q)
      S_IDLE: begin
        idx_d      = '0;
        cmp_vld_d  = 1'b0;
        found_d    = 1'b0;
        free_fnd_d = 1'b0;
        if (in_i.valid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_q) begin
          if (used_q[cmp_idx_q] && key_rdata == code_q) begin
            found_d = 1'b1;
            slot_d  = cmp_idx_q;
          end
          if (!used_q[cmp_idx_q] && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_d     = cmp_idx_q;
          end
        end
        if (idx_q < (KW+1)'(MAX_KEYS)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[KW-1:0];
          idx_d     = idx_q + 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            if (cmd_q == CMD_ADD) begin
              state_d = S_ADDK;
            end else if (!found_q) begin
              state_d = S_NOKEY;
            end else begin
              state_d = S_MRD;
            end
          end
        end
      end
      S_ADDK: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (found_q) begin
            e_st = ST_DUP;
          end else if (!free_fnd_q) begin
            e_st = ST_TFULL;
          end else begin
            key_we         = 1'b1;
            meta_we        = 1'b1;
            meta_waddr     = free_q;
            used_d[free_q] = 1'b1;
          end
        end
      end
      S_NOKEY: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_st    = ST_NOKEY;
          state_d = S_IDLE;
        end
      end
      S_MRD: begin
        state_d = S_MLD;
      end
      S_MLD: begin
        head_d     = meta_rdata[MW-1:CW];
        cnt_d      = meta_rdata[CW-1:0];
        lidx_d     = '0;
        rdv_d      = 1'b0;
        pend_vld_d = 1'b0;
        case (cmd_q)
          CMD_ENQ: state_d = S_ENQ;
          CMD_DEQ: state_d = S_DQ1;
          default: state_d = S_LIST;
        endcase
      end
      S_ENQ: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (cnt_q >= CW'(QUEUE_DEPTH)) begin
            e_st = ST_QFULL;
          end else begin
            ent_we     = 1'b1;
            meta_we    = 1'b1;
            meta_wdata = {head_q, cnt_q + 1'b1};
          end
        end
      end
      S_DQ1: begin
        if (cnt_q == '0) begin
          if (can_emit) begin
            emit    = 1'b1;
            e_st    = ST_EMPTY;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_DQ2;
        end
      end
      S_DQ2: begin
        rem_d   = ent_rdata[IdW-1:0];
        state_d = S_DQ3;
      end
      S_DQ3: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_eid      = rem_q;
          e_ev       = 1'b1;
          e_nv       = (cnt_q > CW'(1));
          e_nid      = e_nv ? ent_rdata[IdW-1:0] : '0;
          meta_we    = 1'b1;
          meta_wdata = {head_nx, cnt_q - 1'b1};
          state_d    = S_IDLE;
        end
      end
      S_LIST: begin
        if (step) begin
          if (rdv_q && ent_rdata[EW-1:IdW] == cat_q) begin
            if (pend_vld_q) begin
              emit   = 1'b1;
              e_eid  = pend_q;
              e_ev   = 1'b1;
              e_last = 1'b0;
            end
            pend_d     = ent_rdata[IdW-1:0];
            pend_vld_d = 1'b1;
          end
          if (lidx_q < cnt_q) begin
            lidx_d = lidx_q + 1'b1;
            rdv_d  = 1'b1;
          end else begin
            rdv_d = 1'b0;
            if (!rdv_q) begin
              state_d = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_eid   = pend_vld_q ? pend_q : '0;
          e_ev    = pend_vld_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      code_q <= in_i.key_code;
      mid_q  <= in_i.member_id;
      cat_q  <= in_i.category;
    end
    idx_q      <= idx_d;
    cmp_vld_q  <= cmp_vld_d;
    cmp_idx_q  <= cmp_idx_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
    free_fnd_q <= free_fnd_d;
    free_q     <= free_d;
    head_q     <= head_d;
    cnt_q      <= cnt_d;
    lidx_q     <= lidx_d;
    rdv_q      <= rdv_d;
    pend_q     <= pend_d;
    pend_vld_q <= pend_vld_d;
    rem_q      <= rem_d;
    if (emit) begin
      o_st_q   <= e_st;
      o_eid_q  <= e_eid;
      o_ev_q   <= e_ev;
      o_nid_q  <= e_nid;
      o_nv_q   <= e_nv;
      o_last_q <= e_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = o_st_q;
  assign out_o.entry_id    = o_eid_q;
  assign out_o.entry_valid = o_ev_q;
  assign out_o.next_id     = o_nid_q;
  assign out_o.next_valid  = o_nv_q;
  assign out_o.last        = o_last_q;

endmodule
